FILE: hw/rtl/wsu_pkg.sv
`timescale 1ns / 1ps

package wsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TERM    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // register indexes, taken from paddr[2]
  localparam logic CFG_APPEND = 1'b0;
  localparam logic CFG_TERM   = 1'b1;

  // one queue entry; dual means the payload beat is followed by a terminator beat
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] term;
    logic [1:0] kind;
    logic       last;
    logic       dual;
  } entry_t;

endpackage

FILE: hw/rtl/wsu_in_if.sv
`timescale 1ns / 1ps

interface wsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/wsu_out_if.sv
`timescale 1ns / 1ps

interface wsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       frame_last;

  modport source (output valid, output out_byte, output kind, output frame_last, input ready);
  modport sink   (input valid, input out_byte, input kind, input frame_last, output ready);
endinterface

FILE: hw/rtl/wsu_front.sv
`timescale 1ns / 1ps

module wsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            append_term,
  input  logic [7:0]      term_byte,
  input  logic            q_full,
  output logic            push,
  output wsu_pkg::entry_t push_entry
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  ext_cnt_r, ext_cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic        close_r, close_nxt;
  logic        fire;
  logic [6:0]  len;
  logic [7:0]  mbyte;
  logic [7:0]  unmasked;
  logic        rem_one;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign len      = in_byte[6:0];
  assign mbyte    = mask_r[{midx_r, 3'b000} +: 8];
  assign unmasked = in_byte ^ mbyte;
  assign rem_one  = (rem_r == 64'd1);

  always_comb begin
    phase_nxt   = phase_r;
    ext_cnt_nxt = ext_cnt_r;
    rem_nxt     = rem_r;
    mask_nxt    = mask_r;
    midx_nxt    = midx_r;
    close_nxt   = close_r;
    push        = 1'b0;
    push_entry  = '{data: unmasked, term: term_byte, kind: wsu_pkg::KIND_PAYLOAD,
                    last: 1'b0, dual: 1'b0};
    if (fire) begin
      unique case (phase_r)
        PH_HDR0: begin
          close_nxt = in_byte[3];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          midx_nxt = 2'd0;
          if (len == 7'd127) begin
            ext_cnt_nxt = 4'd8;
            rem_nxt     = 64'd0;
            phase_nxt   = PH_EXT;
          end else if (len == 7'd126) begin
            ext_cnt_nxt = 4'd2;
            rem_nxt     = 64'd0;
            phase_nxt   = PH_EXT;
          end else begin
            rem_nxt   = {57'd0, len};
            phase_nxt = PH_MASK;
          end
        end
        PH_EXT: begin
          rem_nxt     = {rem_r[55:0], in_byte};
          ext_cnt_nxt = ext_cnt_r - 4'd1;
          if (ext_cnt_r == 4'd1) begin
            phase_nxt = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_nxt[{midx_r, 3'b000} +: 8] = in_byte;
          midx_nxt = midx_r + 2'd1;
          if (midx_r == 2'd3) begin
            if (close_r) begin
              push            = 1'b1;
              push_entry.data = 8'd0;
              push_entry.kind = wsu_pkg::KIND_END;
              push_entry.last = 1'b1;
              phase_nxt       = (rem_r != 64'd0) ? PH_SKIP : PH_HDR0;
            end else if (rem_r == 64'd0) begin
              push            = append_term;
              push_entry.data = term_byte;
              push_entry.kind = wsu_pkg::KIND_TERM;
              push_entry.last = 1'b1;
              phase_nxt       = PH_HDR0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          midx_nxt = midx_r + 2'd1;
          rem_nxt  = rem_r - 64'd1;
          push     = 1'b1;
          if (rem_one) begin
            push_entry.dual = append_term;
            push_entry.last = !append_term;
            phase_nxt       = PH_HDR0;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 64'd1;
          if (rem_one) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      ext_cnt_r <= 4'd0;
      rem_r     <= 64'd0;
      mask_r    <= 32'd0;
      midx_r    <= 2'd0;
      close_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      ext_cnt_r <= ext_cnt_nxt;
      rem_r     <= rem_nxt;
      mask_r    <= mask_nxt;
      midx_r    <= midx_nxt;
      close_r   <= close_nxt;
    end
  end

endmodule

FILE: hw/rtl/wsu_queue.sv
`timescale 1ns / 1ps

module wsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsu_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output wsu_pkg::entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] PTR_ONE  = PW'(1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  wsu_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_ONE;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_ONE;
      end
    end
  end

endmodule

FILE: hw/rtl/wsu_back.sv
`timescale 1ns / 1ps

module wsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  wsu_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  wsu_pkg::entry_t ent_r;
  logic            valid_r;
  logic            half_r;
  logic            advance;
  logic            split;

  assign advance = !valid_r || out_ready;
  // second beat of a dual entry comes from the same register
  assign split   = valid_r && ent_r.dual && !half_r;
  assign pop     = advance && !split && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else if (advance) begin
      if (split) begin
        half_r <= 1'b1;
      end else begin
        valid_r <= head_valid;
        half_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head_entry;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = half_r ? ent_r.term : ent_r.data;
  assign out_kind  = half_r ? wsu_pkg::KIND_TERM : ent_r.kind;
  assign out_last  = half_r ? 1'b1 : ent_r.last;

endmodule

FILE: hw/rtl/websocket_frame_unmasker_core.sv
`timescale 1ns / 1ps

// websocket frame unmasker
// in_chan carries the received frame stream, one raw byte a beat; out_chan
// carries result beats: an unmasked payload byte (kind 0), the terminator
// byte (kind 1) or a connection-end marker (kind 2, byte zero). frame_last
// marks the final beat of each frame's results.
// the front parser takes one byte every cycle while the entry queue has
// room; it tracks header, extended length, mask and payload phases and
// pushes at most one entry per byte. the back stage turns entries into
// beats, splitting a last payload byte in terminator mode into two beats.
// each result passes through the queue and then the output register.
// throughput: one byte per cycle in while the queue has room, one beat per
// cycle out while out_chan is ready; a split terminator beat takes no input byte.
// a stalled receiver fills the queue (QUEUE_DEPTH entries plus the output
// register) and in_chan.ready then drops until beats drain.
// synchronous reset returns the parser to the first header byte, empties
// the queue and clears both registers (append_terminator at 0x0,
// terminator_byte at 0x4, written through the apb port).

module websocket_frame_unmasker_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  wsu_in_if.sink      in_chan,
  wsu_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic       append_r;
  logic [7:0] term_r;
  logic       cfg_wr;

  // front to queue, queue to back
  logic            q_full;
  logic            push;
  wsu_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  wsu_pkg::entry_t head_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      append_r <= 1'b0;
      term_r   <= 8'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        wsu_pkg::CFG_APPEND: append_r <= pwdata[0];
        wsu_pkg::CFG_TERM:   term_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      wsu_pkg::CFG_APPEND: prdata = {31'd0, append_r};
      wsu_pkg::CFG_TERM:   prdata = {24'd0, term_r};
      default:             prdata = 32'd0;
    endcase
  end

  // header parse and unmask
  wsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_byte     (in_chan.in_byte),
    .append_term (append_r),
    .term_byte   (term_r),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // decoupling queue
  wsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // beat issue with output register
  wsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_byte   (out_chan.out_byte),
    .out_kind   (out_chan.kind),
    .out_last   (out_chan.frame_last)
  );

endmodule

FILE: verif/websocket_frame_unmasker_core_test.sv
`timescale 1ns / 1ps

module websocket_frame_unmasker_core_test;

  // length byte escapes for the extended length forms
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // how a test frame encodes its payload length
  localparam int ENC_SHORT = 0;
  localparam int ENC_16    = 1;
  localparam int ENC_64    = 2;

  // receiver hold-off length, settle time before a register write, quiet-cycle limit
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE_TICKS = 8;
  localparam int QUIET_LIMIT  = 2000;

  // predicts the beats for each accepted byte and checks them in order
  class frame_scoreboard;
    typedef enum logic [2:0] {
      AWAIT_HDR0, AWAIT_LEN, EXT_LEN, MASK_KEY, IN_PAYLOAD, SKIP_CLOSE
    } parse_state_t;

    typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
    } beat_t;

    logic         append_term;
    logic [7:0]   term_byte;
    parse_state_t state;
    logic [3:0]   ext_left;
    logic [63:0]  remaining;
    logic [31:0]  mask_key;
    logic [1:0]   key_idx;
    logic         is_close;
    beat_t        expected_q[$];
    int           mismatches;

    function new();
      append_term = 1'b0;
      term_byte   = 8'h00;
      state       = AWAIT_HDR0;
      ext_left    = '0;
      remaining   = '0;
      mask_key    = '0;
      key_idx     = '0;
      is_close    = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] value);
      if (idx == wsu_pkg::CFG_APPEND) append_term = value[0];
      else term_byte = value[7:0];
    endfunction

    function void push_beat(logic [7:0] data, logic [1:0] kind, logic last);
      expected_q.push_back(beat_t'{data, kind, last});
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] plain;
      case (state)
        AWAIT_HDR0: begin
          is_close = b[3];
          state = AWAIT_LEN;
        end
        AWAIT_LEN: begin
          key_idx = '0;
          if (b[6:0] == LEN_EXT64) begin
            ext_left = 4'd8;
            remaining = '0;
            state = EXT_LEN;
          end else if (b[6:0] == LEN_EXT16) begin
            ext_left = 4'd2;
            remaining = '0;
            state = EXT_LEN;
          end else begin
            remaining = 64'(b[6:0]);
            state = MASK_KEY;
          end
        end
        EXT_LEN: begin
          remaining = {remaining[55:0], b};
          ext_left--;
          if (ext_left == 0) state = MASK_KEY;
        end
        MASK_KEY: begin
          mask_key[8*key_idx +: 8] = b;
          if (key_idx != 2'd3) begin
            key_idx++;
          end else begin
            key_idx = '0;
            if (is_close) begin
              push_beat(8'h00, wsu_pkg::KIND_END, 1'b1);
              state = (remaining != 0) ? SKIP_CLOSE : AWAIT_HDR0;
            end else if (remaining == 0) begin
              if (append_term) push_beat(term_byte, wsu_pkg::KIND_TERM, 1'b1);
              state = AWAIT_HDR0;
            end else begin
              state = IN_PAYLOAD;
            end
          end
        end
        IN_PAYLOAD: begin
          plain = b ^ mask_key[8*key_idx +: 8];
          key_idx++;
          remaining--;
          if (remaining != 0) begin
            push_beat(plain, wsu_pkg::KIND_PAYLOAD, 1'b0);
          end else begin
            push_beat(plain, wsu_pkg::KIND_PAYLOAD, !append_term);
            if (append_term) push_beat(term_byte, wsu_pkg::KIND_TERM, 1'b1);
            state = AWAIT_HDR0;
          end
        end
        SKIP_CLOSE: begin
          remaining--;
          if (remaining == 0) state = AWAIT_HDR0;
        end
        default: state = AWAIT_HDR0;
      endcase
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_beat(logic [7:0] data, logic [1:0] kind, logic last);
      beat_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat byte %02h kind %0d last %0b", data, kind, last));
        return;
      end
      exp = expected_q.pop_front();
      if (data !== exp.data)
        report($sformatf("out_byte %02h, expected %02h", data, exp.data));
      if (kind !== exp.kind)
        report($sformatf("kind %0d, expected %0d", kind, exp.kind));
      if (last !== exp.last)
        report($sformatf("frame_last %0b, expected %0b", last, exp.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wsu_in_if  in_chan();
  wsu_out_if out_chan();

  websocket_frame_unmasker_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  frame_scoreboard sb = new();

  // state used by the sender, the receiver and the watchdog
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int bytes_sent   = 0;
  int hold_left    = 0;
  int quiet        = 0;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one byte, with random idle cycles ahead of it, and wait for the beat
  task automatic send_byte(input logic [7:0] b);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // one whole frame: header, optional extended length, key, payload
  task automatic send_frame(input logic [7:0] hdr0, input logic mask_bit,
                            input logic [63:0] len, input int enc,
                            input logic [31:0] key, input bit use_fill,
                            input logic [7:0] fill);
    send_byte(hdr0);
    case (enc)
      ENC_16: begin
        send_byte({mask_bit, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      ENC_64: begin
        send_byte({mask_bit, LEN_EXT64});
        // big-endian, most significant byte first
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: send_byte({mask_bit, len[6:0]});
    endcase
    // first key byte on the wire unmasks payload byte 0
    for (int i = 0; i < 4; i++) send_byte(key[8*i +: 8]);
    for (longint i = 0; i < len; i++)
      send_byte(use_fill ? (fill ^ (i[0] ? 8'hff : 8'h00)) : 8'($urandom));
  endtask

  // mostly short data frames, some close frames, a few long ones
  task automatic send_random_frame();
    logic [7:0] hdr0;
    int         pick;
    int         len;
    int         enc;
    hdr0 = 8'($urandom);
    hdr0[3] = ($urandom_range(99) < 20);
    pick = $urandom_range(99);
    if (pick < 10) len = 0;
    else if (pick < 80) len = $urandom_range(12, 1);
    else if (pick < 95) len = $urandom_range(125, 13);
    else len = $urandom_range(300, 126);
    // longer lengths need an escape; short ones sometimes use one anyway
    if (len > 125 || $urandom_range(99) < 15) enc = $urandom_range(ENC_64, ENC_16);
    else enc = ENC_SHORT;
    send_frame(hdr0, 1'($urandom), 64'(len), enc, $urandom, 1'b0, 8'h00);
  endtask

  // let every expected beat arrive, then give trailing bytes time to clear
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready, then back to idle
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
    @(posedge clk);
  endtask

  // random traffic under one setting of the idle rates
  task automatic run_random(input int n_bytes, input int in_pct, input int out_pct,
                            input bit hold);
    int goal;
    goal = bytes_sent + n_bytes;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    if (hold) hold_off_req = 1'b1;
    while (bytes_sent < goal) send_random_frame();
    settle();
  endtask

  // receiver: checks every beat; random stalls, plus one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        sb.check_beat(out_chan.out_byte, out_chan.kind, out_chan.frame_last);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_off_req) begin
        // sender keeps offering, so the queue fills and in_chan.ready drops
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // watchdog: too many cycles without a beat on either side ends the run
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= 8'h00;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames with the reset settings (no terminator)
    // zero-length data frame, mask bit set: no beat at all
    send_frame(8'h81, 1'b1, 64'd0, ENC_SHORT, $urandom, 1'b0, 8'h00);
    // zero key, so the payload comes out as 00 ff 00 ff
    send_frame(8'h02, 1'b1, 64'd4, ENC_SHORT, 32'h0000_0000, 1'b1, 8'h00);
    // close frame: end marker, then its payload is dropped
    send_frame(8'h88, 1'b0, 64'd2, ENC_SHORT, $urandom, 1'b0, 8'h00);
    // all-ones opcode byte is a close frame; all-zero length byte
    send_frame(8'hff, 1'b0, 64'd0, ENC_SHORT, 32'hffff_ffff, 1'b0, 8'h00);
    // 16-bit length form, all-ones key gives ff 00 ff
    send_frame(8'h00, 1'b0, 64'd3, ENC_16, 32'hffff_ffff, 1'b1, 8'h00);
    // 64-bit length form with the length byte at all ones
    send_frame(8'h01, 1'b1, 64'd1, ENC_64, 32'h5a3c_c3a5, 1'b0, 8'h00);
    settle();

    // terminator mode, marker 0xa5, both sides idling
    cfg_write(wsu_pkg::CFG_APPEND, 32'h0000_0001);
    cfg_write(wsu_pkg::CFG_TERM, 32'h0000_00a5);
    run_random(400, 35, 35, 1'b0);

    // marker masked down to zero; no idling, with one long receiver hold-off
    cfg_write(wsu_pkg::CFG_TERM, 32'hffff_ff00);
    run_random(400, 0, 0, 1'b1);

    // terminator off through a masked write, marker at all ones
    cfg_write(wsu_pkg::CFG_APPEND, 32'hffff_fffe);
    cfg_write(wsu_pkg::CFG_TERM, 32'h0000_00ff);
    run_random(400, 35, 0, 1'b0);

    cfg_write(wsu_pkg::CFG_APPEND, 32'h0000_0001);
    run_random(350, 0, 35, 1'b0);

    cfg_write(wsu_pkg::CFG_TERM, $urandom);
    run_random(350, 35, 35, 1'b0);

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
